// ===== hdl/aod_pkg.sv =====
package aod_pkg;

	// log2 core: mantissa held as Q1.30, one fraction bit per squaring
	localparam int LOG_FRAC  = 24;
	localparam int MANT_FRAC = 30;
	localparam int MANT_W    = MANT_FRAC + 1;

	// round(ln2 * 2^32)
	localparam int LN2_W = 32;
	localparam logic [LN2_W-1:0] LN2_Q32 = 32'd2977044472;

	localparam int DENSITY_W        = 17;
	localparam int DENSITY_MAX_MAG  = 65535;
	localparam int DENSITY_MIN_MAG  = 65536;
	localparam logic signed [DENSITY_W-1:0] DENSITY_MAX = 17'sh0FFFF;
	localparam logic signed [DENSITY_W-1:0] DENSITY_MIN = 17'sh10000;

	localparam int PIXEL_BITS_DEF        = 16;
	localparam int DENSITY_FRAC_BITS_DEF = 12;

endpackage

// ===== hdl/absorption_optical_density_unit.sv =====
// Optical density ln(beam/atom) per pixel pair, signed, DENSITY_FRAC_BITS fraction bits.
// A new pixel pair may be started on every clock; busy is always low. Each result
// appears on density/density_valid with a one-cycle done strobe after passing through
// one normalize stage, one stage per log2 fraction bit (a squaring multiplier for each
// of the two pixels), a subtract stage, an ln2 scaling multiplier and a
// round/saturate stage. Results come out in start order and cannot be held off.
// A zero pixel gives density 0 with density_valid low.
module absorption_optical_density_unit
	import aod_pkg::*;
#(
	parameter int PIXEL_BITS        = PIXEL_BITS_DEF,
	parameter int DENSITY_FRAC_BITS = DENSITY_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [PIXEL_BITS-1:0]       atom_pixel,
	input  logic [PIXEL_BITS-1:0]       beam_pixel,
	output logic                        done,
	output logic signed [DENSITY_W-1:0] density,
	output logic                        density_valid
);

	localparam int EXP_W  = $clog2(PIXEL_BITS);
	localparam int LOG_W  = EXP_W + LOG_FRAC;
	localparam int PROD_W = LOG_W + LN2_W;
	localparam int SH     = LOG_FRAC + LN2_W - DENSITY_FRAC_BITS;
	localparam int LAT    = LOG_FRAC + 4;

	function automatic logic [EXP_W-1:0] msb_pos(input logic [PIXEL_BITS-1:0] x);
		logic [EXP_W-1:0] p;
		p = '0;
		for (int i = 0; i < PIXEL_BITS; i++) begin
			if (x[i]) p = EXP_W'(i);
		end
		return p;
	endfunction

	function automatic logic [MANT_W-1:0] normalize(input logic [PIXEL_BITS-1:0] x,
		input logic [EXP_W-1:0] e);
		logic [PIXEL_BITS-1:0] xn;
		xn = x << (EXP_W'(PIXEL_BITS - 1) - e);
		return {xn, {(MANT_W - PIXEL_BITS){1'b0}}};
	endfunction

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// stage 1 and squaring stages share arrays: index 0 is the normalize stage
	logic                v_s      [0:LOG_FRAC];
	logic                ok_s     [0:LOG_FRAC];
	logic [EXP_W-1:0]    ea_s     [0:LOG_FRAC];
	logic [EXP_W-1:0]    eb_s     [0:LOG_FRAC];
	logic [MANT_W-1:0]   ma_s     [0:LOG_FRAC];
	logic [MANT_W-1:0]   mb_s     [0:LOG_FRAC];
	logic [LOG_FRAC-1:0] fa_s     [0:LOG_FRAC];
	logic [LOG_FRAC-1:0] fb_s     [0:LOG_FRAC];

	logic [MANT_W:0]     sqa      [0:LOG_FRAC-1];
	logic [MANT_W:0]     sqb      [0:LOG_FRAC-1];

	logic [EXP_W-1:0] ea_in, eb_in;
	assign ea_in = msb_pos(atom_pixel);
	assign eb_in = msb_pos(beam_pixel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LOG_FRAC; k++) v_s[k] <= 1'b0;
		end else begin
			v_s[0] <= accept;
			for (int k = 0; k < LOG_FRAC; k++) v_s[k+1] <= v_s[k];
		end
	end

	// square truncated to Q2.30; bit 1 of the integer part is the next fraction bit
	always_comb begin
		logic [2*MANT_W-1:0] pa, pb;
		for (int k = 0; k < LOG_FRAC; k++) begin
			pa     = ma_s[k] * ma_s[k];
			pb     = mb_s[k] * mb_s[k];
			sqa[k] = pa[MANT_FRAC +: MANT_W+1];
			sqb[k] = pb[MANT_FRAC +: MANT_W+1];
		end
	end

	always_ff @(posedge clk) begin
		ok_s[0] <= (atom_pixel != '0) && (beam_pixel != '0);
		ea_s[0] <= ea_in;
		eb_s[0] <= eb_in;
		ma_s[0] <= normalize(atom_pixel, ea_in);
		mb_s[0] <= normalize(beam_pixel, eb_in);
		fa_s[0] <= '0;
		fb_s[0] <= '0;
		for (int k = 0; k < LOG_FRAC; k++) begin
			ok_s[k+1] <= ok_s[k];
			ea_s[k+1] <= ea_s[k];
			eb_s[k+1] <= eb_s[k];
			ma_s[k+1] <= sqa[k][MANT_W] ? sqa[k][MANT_W:1] : sqa[k][MANT_W-1:0];
			mb_s[k+1] <= sqb[k][MANT_W] ? sqb[k][MANT_W:1] : sqb[k][MANT_W-1:0];
			fa_s[k+1] <= {fa_s[k][LOG_FRAC-2:0], sqa[k][MANT_W]};
			fb_s[k+1] <= {fb_s[k][LOG_FRAC-2:0], sqb[k][MANT_W]};
		end
	end

	// difference stage
	logic [LOG_W:0]   diff;
	logic             v_sd, ok_sd, neg_sd;
	logic [LOG_W-1:0] mag_sd;

	assign diff = {1'b0, eb_s[LOG_FRAC], fb_s[LOG_FRAC]} - {1'b0, ea_s[LOG_FRAC], fa_s[LOG_FRAC]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sd <= 1'b0;
		else         v_sd <= v_s[LOG_FRAC];
	end

	always_ff @(posedge clk) begin
		ok_sd  <= ok_s[LOG_FRAC];
		neg_sd <= diff[LOG_W];
		mag_sd <= diff[LOG_W] ? LOG_W'(-diff) : diff[LOG_W-1:0];
	end

	// ln2 scaling stage
	logic              v_sm, ok_sm, neg_sm;
	logic [PROD_W-1:0] prod_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sm <= 1'b0;
		else         v_sm <= v_sd;
	end

	always_ff @(posedge clk) begin
		ok_sm   <= ok_sd;
		neg_sm  <= neg_sd;
		prod_sm <= PROD_W'(mag_sd) * PROD_W'(LN2_Q32);
	end

	// round half away from zero on the magnitude, then saturate
	logic [PROD_W:0]             rnd, q;
	logic signed [DENSITY_W-1:0] res;

	always_comb begin
		rnd = {1'b0, prod_sm} + ((PROD_W+1)'(1) << (SH - 1));
		q   = rnd >> SH;
		if (neg_sm) begin
			if (q > (PROD_W+1)'(DENSITY_MIN_MAG)) res = DENSITY_MIN;
			else                                  res = -$signed(q[DENSITY_W-1:0]);
		end else begin
			if (q > (PROD_W+1)'(DENSITY_MAX_MAG)) res = DENSITY_MAX;
			else                                  res = $signed(q[DENSITY_W-1:0]);
		end
	end

	logic                        done_q, valid_q;
	logic signed [DENSITY_W-1:0] density_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= v_sm;
	end

	always_ff @(posedge clk) begin
		valid_q   <= ok_sm;
		density_q <= ok_sm ? res : '0;
	end

	assign done          = done_q;
	assign density       = density_q;
	assign density_valid = valid_q;

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without a start");

	a_valid_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> density_valid == $past(atom_pixel != '0 && beam_pixel != '0, LAT))
		else $error("valid flag does not match pixels");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !density_valid |-> density == '0)
		else $error("invalid result not zero");

	a_equal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && density_valid && $past(atom_pixel == beam_pixel, LAT) |-> density == '0)
		else $error("equal pixels give nonzero density");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		done && density_valid && density[DENSITY_W-1] |-> $past(beam_pixel < atom_pixel, LAT))
		else $error("negative density with beam not below atom");

endmodule
